// ----- hdl/ppa_pkg.sv -----
// ----------------------------------------------------------------------------
// ppa_pkg
// shared types and constants of the polygon perimeter accumulator
// ----------------------------------------------------------------------------
package ppa_pkg;

    localparam int COORD_W   = 16;
    localparam int SUM_W     = 32;
    localparam int SQ_W      = 2 * COORD_W;
    // radicand holds the carry of the sum of squares, padded to an even width
    localparam int RAD_W     = 2 * COORD_W + 2;
    localparam int ROOT_W    = COORD_W + 1;
    localparam int REM_W     = ROOT_W + 3;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int CNT_W     = $clog2(ROOT_STEPS);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_vertex;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] perimeter;
        logic             saturated;
    } out_item_t;

    // one queued job per vertex
    typedef struct packed {
        logic               start;     // first vertex of a polygon, clear the sum
        logic               has_open;  // edge from the previous vertex
        logic               last;      // add closing edge and emit
        logic [COORD_W-1:0] dx_open;
        logic [COORD_W-1:0] dy_open;
        logic [COORD_W-1:0] dx_close;
        logic [COORD_W-1:0] dy_close;
    } job_t;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        if (d[COORD_W])
        begin
            return n[COORD_W-1:0];
        end
        return d[COORD_W-1:0];
    endfunction

endpackage

// ----- hdl/ppa_front.sv -----
// ----------------------------------------------------------------------------
// ppa_front
// accepts vertices, tracks first and previous vertex, builds edge jobs
// ----------------------------------------------------------------------------
module ppa_front
    import ppa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     q_push,
    output job_t     q_job
);

    logic                      have_vertex_reg;
    logic                      have_vertex_next;
    logic signed [COORD_W-1:0] first_x_reg;
    logic signed [COORD_W-1:0] first_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // closing edge goes back to the first vertex, or to itself on a lone vertex
    assign ref_x = have_vertex_reg ? first_x_reg : in_data.x_coord;
    assign ref_y = have_vertex_reg ? first_y_reg : in_data.y_coord;

    always_comb
    begin
        q_job.start    = !have_vertex_reg;
        q_job.has_open = have_vertex_reg;
        q_job.last     = in_data.last_vertex;
        q_job.dx_open  = abs_diff(prev_x_reg, in_data.x_coord);
        q_job.dy_open  = abs_diff(prev_y_reg, in_data.y_coord);
        q_job.dx_close = abs_diff(in_data.x_coord, ref_x);
        q_job.dy_close = abs_diff(in_data.y_coord, ref_y);
        have_vertex_next = have_vertex_reg;
        if (q_push)
        begin
            have_vertex_next = !in_data.last_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_vertex_reg <= 1'b0;
        end
        else
        begin
            have_vertex_reg <= have_vertex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            prev_x_reg <= in_data.x_coord;
            prev_y_reg <= in_data.y_coord;
            if (!have_vertex_reg)
            begin
                first_x_reg <= in_data.x_coord;
                first_y_reg <= in_data.y_coord;
            end
        end
    end

endmodule

// ----- hdl/ppa_queue.sv -----
// ----------------------------------------------------------------------------
// ppa_queue
// small job queue between front and back
// ----------------------------------------------------------------------------
module ppa_queue
    import ppa_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_QW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(FIFO_DEPTH);

    job_t              mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

// ----- hdl/ppa_back.sv -----
// ----------------------------------------------------------------------------
// ppa_back
// squares, bit-serial integer square root, saturating sum and result register
// ----------------------------------------------------------------------------
module ppa_back
    import ppa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  job_t      q_job,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_LD   = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(ROOT_STEPS - 1);

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    job_t              job_reg;
    logic              close_reg;
    logic              close_next;
    logic [SQ_W-1:0]   sx_reg;
    logic [SQ_W-1:0]   sy_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;

    logic [COORD_W-1:0] dx_sel;
    logic [COORD_W-1:0] dy_sel;
    logic [1:0]         pair;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               take;
    logic [SUM_W:0]     sum_ext;
    logic               emit_fire;

    assign dx_sel = close_reg ? job_reg.dx_close : job_reg.dx_open;
    assign dy_sel = close_reg ? job_reg.dy_close : job_reg.dy_open;

    // one root bit per cycle, radicand consumed two bits at a time from the top
    assign pair   = rad_reg[RAD_W-1 -: 2];
    assign rem_sh = {rem_reg[REM_W-3:0], pair};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    assign sum_ext   = {1'b0, sum_reg} + (SUM_W + 1)'(root_reg);
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        close_next     = close_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_job.start)
                    begin
                        sum_next = '0;
                        ovf_next = 1'b0;
                    end
                    close_next = !q_job.has_open;
                    if (q_job.has_open || q_job.last)
                    begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ:
            begin
                state_next = ST_LD;
            end
            ST_LD:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (sum_ext >= (SUM_W + 1)'(SUM_MAX))
                begin
                    sum_next = SUM_MAX;
                    ovf_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_ext[SUM_W-1:0];
                end
                if (job_reg.last && !close_reg)
                begin
                    close_next = 1'b1;
                    state_next = ST_SQ;
                end
                else if (job_reg.last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            close_reg     <= 1'b0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            close_reg     <= close_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (state_reg == ST_SQ)
        begin
            sx_reg <= SQ_W'(dx_sel) * SQ_W'(dx_sel);
            sy_reg <= SQ_W'(dy_sel) * SQ_W'(dy_sel);
        end
        if (state_reg == ST_LD)
        begin
            rad_reg  <= RAD_W'(sx_reg) + RAD_W'(sy_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CNT_TOP;
        end
        if (state_reg == ST_ROOT)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
            cnt_reg  <= cnt_reg - 1'b1;
        end
        if (emit_fire)
        begin
            out_data_reg.perimeter <= sum_reg;
            out_data_reg.saturated <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (sum_reg == SUM_MAX))
        else $error("overflow flag without saturated sum");

    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) && (cnt_reg == '0) |=> (state_reg == ST_ACC))
        else $error("root iteration count lost");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside emit");

endmodule

// ----- hdl/polygon_perimeter_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// polygon_perimeter_accumulator_top
// euclidean perimeter of closed polygons from a stream of q8.8 vertices
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  in      | input     | in_valid/in_stall | in_item_t  x, y, last_vertex
//  out     | output    | out_valid/out_stall | out_item_t perimeter, saturated
//
//  a vertex is popped in the idle state; each edge then runs the squares, load,
//  17 root steps of the bit-serial square root, and the saturating add
//  a middle vertex adds its open edge, a last vertex both edges and then emits,
//  a lone vertex only its closing edge and then emits, a first vertex not last none
//  reset clears all control state, the job queue and the running sum
//  in_stall follows the job queue only; the front keeps taking vertices
//  while the back works or while a result waits on out_stall, as long as the queue has room
//
module polygon_perimeter_accumulator_top
    import ppa_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    // front to queue
    logic q_push;
    logic q_full;
    job_t push_job;

    // queue to back
    logic q_pop;
    logic q_empty;
    job_t pop_job;

    // front: vertex bookkeeping and edge differences
    ppa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    // decoupling queue, one job per vertex
    ppa_queue #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // back: edge lengths, running sum, result register
    ppa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
